>>> hw/rtl/ecmp_pkg.sv
`default_nettype none

package ecmp_pkg;

  localparam int unsigned MAX_PATHS   = 16;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NSTAGE      = 12;

  localparam logic [31:0] MH_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MH_C2     = 32'h1b873593;
  localparam logic [31:0] MH_N      = 32'he6546b64;
  localparam logic [31:0] MH_F1     = 32'h85ebca6b;
  localparam logic [31:0] MH_F2     = 32'hc2b2ae35;
  localparam logic [31:0] KEY_BYTES = 32'd12;
  localparam logic [7:0]  PROTO_UDP = 8'h11;

  typedef struct packed {
    logic [31:0]      w0;
    logic [31:0]      w1;
    logic [31:0]      w2;
    logic [CNT_W-1:0] count;
    logic             drop;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ecmp_front.sv
`default_nettype none

module ecmp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [31:0]     source_address_i,
  input  wire logic [31:0]     destination_address_i,
  input  wire logic [15:0]     source_port_i,
  input  wire logic [15:0]     destination_port_i,
  input  wire logic [7:0]      ip_protocol_i,
  input  wire logic [4:0]      path_count_i,
  input  wire ecmp_pkg::queue_status_t q_status_i,
  output logic                 push_o,
  output ecmp_pkg::item_t      item_o
);
  import ecmp_pkg::*;

  logic             vld_q, vld_d;
  item_t            item_q, item_d;
  logic             accept;
  logic [CNT_W-1:0] count_sat;

  assign in_stall_o = vld_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = vld_q && !q_status_i.full;
  assign item_o     = item_q;

  always_comb begin
    count_sat = (path_count_i > CNT_W'(MAX_PATHS)) ? CNT_W'(MAX_PATHS) : path_count_i;
    item_d.w0    = source_address_i;
    item_d.w1    = destination_address_i;
    item_d.w2    = {destination_port_i, source_port_i};
    item_d.count = count_sat;
    item_d.drop  = (count_sat == '0) || (ip_protocol_i != PROTO_UDP);
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ecmp_queue.sv
`default_nettype none

module ecmp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ecmp_pkg::item_t item_i,
  input  wire logic            pop_i,
  output ecmp_pkg::queue_status_t status_o,
  output ecmp_pkg::item_t      item_o
);
  import ecmp_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ecmp_back.sv
`default_nettype none

module ecmp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] seed_i,
  input  wire logic        q_valid_i,
  input  wire ecmp_pkg::item_t item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       path_index_o,
  output logic             dropped_o,
  output logic [31:0]      flow_hash_o
);
  import ecmp_pkg::*;

  function automatic logic [31:0] mix_h(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] x;
    x = h ^ k;
    x = {x[18:0], x[31:19]};
    return {x[29:0], 2'b00} + x + MH_N;
  endfunction

  function automatic logic [IDX_W-1:0] mod_byte(input logic [IDX_W-1:0] r,
                                                input logic [7:0] b,
                                                input logic [CNT_W-1:0] n);
    logic [IDX_W-1:0] acc;
    logic [CNT_W-1:0] t;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      t = {acc, b[i]};
      if (t >= n) begin
        t = t - n;
      end
      acc = t[IDX_W-1:0];
    end
    return acc;
  endfunction

  logic [NSTAGE-1:0] vld_q, vld_d;
  logic              en;

  logic [CNT_W-1:0]  cnt_q  [NSTAGE];
  logic              drop_q [NSTAGE];
  logic [31:0]       ka_q [3];
  logic [31:0]       kb_q [3];
  logic [31:0]       k1d_q, k2d_q, k2dd_q;
  logic [31:0]       h2_q, h3_q, h4_q, f5_q, f6_q, hf_q;
  logic [31:0]       hc8_q, hc9_q, hc10_q;
  logic [IDX_W-1:0]  r8_q, r9_q, r10_q;
  logic [IDX_W-1:0]  idx_q;
  logic [31:0]       hash_q;
  logic [31:0]       f5_x, f6_x;
  logic [IDX_W-1:0]  r_last;

  assign en           = !(vld_q[NSTAGE-1] && out_stall_i);
  assign pop_o        = en && q_valid_i;
  assign out_valid_o  = vld_q[NSTAGE-1];
  assign path_index_o = idx_q;
  assign dropped_o    = drop_q[NSTAGE-1];
  assign flow_hash_o  = hash_q;

  assign vld_d = {vld_q[NSTAGE-2:0], q_valid_i};

  always_comb begin
    f5_x   = h4_q ^ KEY_BYTES;
    f5_x   = f5_x ^ (f5_x >> 16);
    f6_x   = f5_q ^ (f5_q >> 13);
    r_last = mod_byte(r10_q, hc10_q[7:0], cnt_q[NSTAGE-2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q[0]  <= item_i.count;
      drop_q[0] <= item_i.drop;
      for (int s = 1; s < NSTAGE; s++) begin
        cnt_q[s]  <= cnt_q[s-1];
        drop_q[s] <= drop_q[s-1];
      end

      ka_q[0] <= item_i.w0 * MH_C1;
      ka_q[1] <= item_i.w1 * MH_C1;
      ka_q[2] <= item_i.w2 * MH_C1;
      for (int j = 0; j < 3; j++) begin
        kb_q[j] <= {ka_q[j][16:0], ka_q[j][31:17]} * MH_C2;
      end

      k1d_q  <= kb_q[1];
      k2d_q  <= kb_q[2];
      k2dd_q <= k2d_q;

      h2_q <= mix_h(seed_i, kb_q[0]);
      h3_q <= mix_h(h2_q, k1d_q);
      h4_q <= mix_h(h3_q, k2dd_q);
      f5_q <= f5_x * MH_F1;
      f6_q <= f6_x * MH_F2;
      hf_q <= f6_q ^ (f6_q >> 16);

      r8_q   <= mod_byte('0, hf_q[31:24], cnt_q[7]);
      hc8_q  <= hf_q;
      r9_q   <= mod_byte(r8_q, hc8_q[23:16], cnt_q[8]);
      hc9_q  <= hc8_q;
      r10_q  <= mod_byte(r9_q, hc9_q[15:8], cnt_q[9]);
      hc10_q <= hc9_q;

      idx_q  <= drop_q[NSTAGE-2] ? '0 : r_last;
      hash_q <= drop_q[NSTAGE-2] ? '0 : hc10_q;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ecmp_next_hop_hash.sv
`default_nettype none

// ECMP next-hop selection: each packet's flow key (source address, destination
// address, and a word of source port low / destination port high) is hashed
// with MurmurHash3 x86_32 from the seed in hash_seed, and the hash modulo the
// path count (saturated at 16) picks the next hop. Packets with a zero path
// count or a protocol other than UDP come out with dropped set and index and
// hash both zero. One transaction is accepted per cycle while in_stall_o is
// low; one result per transaction leaves in order. Each transaction passes
// through the input register, the four-entry queue and the hash pipeline,
// whose depth is set by at most one 32-bit multiplier in series per stage
// and a modulo unit that retires eight hash bits per stage. The seed may only be
// written while no transaction is in flight; cfg_ready_o is always high.
module ecmp_next_hop_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_hash_seed_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] destination_address_i,
  input  wire logic [15:0] source_port_i,
  input  wire logic [15:0] destination_port_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [4:0]  path_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       path_index_o,
  output logic             dropped_o,
  output logic [31:0]      flow_hash_o
);
  import ecmp_pkg::*;

  logic [31:0]   seed_q;
  logic          push;
  logic          pop;
  item_t         front_item;
  item_t         queue_item;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_hash_seed_i;
    end
  end

  ecmp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .source_address_i,
    .destination_address_i,
    .source_port_i,
    .destination_port_i,
    .ip_protocol_i,
    .path_count_i,
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (front_item)
  );

  ecmp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .status_o (q_status),
    .item_o   (queue_item)
  );

  ecmp_back u_back (
    .clk_i,
    .rst_ni,
    .seed_i    (seed_q),
    .q_valid_i (q_status.valid),
    .item_i    (queue_item),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .path_index_o,
    .dropped_o,
    .flow_hash_o
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("queue push while full");

  a_drop_clears_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> path_index_o == '0 && flow_hash_o == '0)
    else $error("dropped result with nonzero index or hash");

  a_stall_only_when_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_status.full)
    else $error("input stalled with room in queue");

endmodule

`default_nettype wire
